@@ rtl/csc_pkg.sv @@
// csc_pkg: shared constants, operation codes and controller/datapath types
// for the checked stack calculator; no dependencies
`default_nettype none

package csc_pkg;

   localparam int STACK_DEPTH = 1024;
   localparam int OP_W        = 4;
   localparam int VAL_W       = 31;
   localparam int RES_W       = 2 * VAL_W;
   localparam int MAG_W       = VAL_W - 1;
   localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
   localparam int ADDR_W      = $clog2(STACK_DEPTH);
   localparam int STEP_W      = $clog2(MAG_W);

   localparam logic signed [VAL_W-1:0] LIMIT_VAL = VAL_W'(1000000000);
   localparam logic signed [RES_W-1:0] LIMIT_RES = RES_W'(1000000000);

   localparam logic [OP_W-1:0] OP_START  = 4'd0;
   localparam logic [OP_W-1:0] OP_NUM    = 4'd1;
   localparam logic [OP_W-1:0] OP_POP    = 4'd2;
   localparam logic [OP_W-1:0] OP_INV    = 4'd3;
   localparam logic [OP_W-1:0] OP_DUP    = 4'd4;
   localparam logic [OP_W-1:0] OP_SWP    = 4'd5;
   localparam logic [OP_W-1:0] OP_ADD    = 4'd6;
   localparam logic [OP_W-1:0] OP_SUB    = 4'd7;
   localparam logic [OP_W-1:0] OP_MUL    = 4'd8;
   localparam logic [OP_W-1:0] OP_DIV    = 4'd9;
   localparam logic [OP_W-1:0] OP_MOD    = 4'd10;
   localparam logic [OP_W-1:0] OP_FINISH = 4'd11;

   // stack address selects
   localparam logic [1:0] A_TOP    = 2'd0;
   localparam logic [1:0] A_SECOND = 2'd1;
   localparam logic [1:0] A_PUSH   = 2'd2;
   localparam logic [1:0] A_BOTTOM = 2'd3;

   // write data selects
   localparam logic [2:0] D_OPERAND = 3'd0;
   localparam logic [2:0] D_READ    = 3'd1;
   localparam logic [2:0] D_NEG     = 3'd2;
   localparam logic [2:0] D_RHS     = 3'd3;
   localparam logic [2:0] D_RESULT  = 3'd4;

   // stack count updates
   localparam logic [2:0] CNT_HOLD = 3'd0;
   localparam logic [2:0] CNT_ZERO = 3'd1;
   localparam logic [2:0] CNT_ONE  = 3'd2;
   localparam logic [2:0] CNT_INC  = 3'd3;
   localparam logic [2:0] CNT_DEC  = 3'd4;
   localparam logic [2:0] CNT_SUB2 = 3'd5;

   typedef struct packed {
      logic            capture;
      logic [OP_W-1:0] op;
      logic            rd_en;
      logic [1:0]      rd_addr_sel;
      logic            wr_en;
      logic [1:0]      wr_addr_sel;
      logic [2:0]      wr_data_sel;
      logic [2:0]      cnt_op;
      logic            err_set;
      logic            err_clr;
      logic            rhs_load;
      logic            res_load_arith;
      logic            res_load_div;
      logic            div_start;
      logic            rsp_load;
   } csc_cmd_type;

   typedef struct packed {
      logic empty;
      logic lt2;
      logic full;
      logic err;
      logic operand_ok;
      logic rhs_zero;
      logic res_ok;
      logic div_done;
      logic rsp_free;
   } csc_status_type;

endpackage

`default_nettype wire

@@ rtl/csc_divider.sv @@
// csc_divider: iterative restoring divider, one quotient bit per cycle,
// truncating quotient and dividend-signed remainder; uses csc_pkg
`default_nettype none

module csc_divider (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             start,
   input  wire logic signed [csc_pkg::VAL_W-1:0] dividend,
   input  wire logic signed [csc_pkg::VAL_W-1:0] divisor,
   output logic                                  done,
   output logic signed [csc_pkg::VAL_W-1:0]      quotient,
   output logic signed [csc_pkg::VAL_W-1:0]      remainder
);
   import csc_pkg::*;

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [MAG_W-1:0]  quo_ff, quo_in;
   logic [MAG_W-1:0]  rem_ff, rem_in;
   logic [MAG_W-1:0]  dvs_ff, dvs_in;
   logic              neg_q_ff, neg_q_in;
   logic              neg_r_ff, neg_r_in;

   logic [VAL_W-1:0]  mag_a;
   logic [VAL_W-1:0]  mag_b;
   logic [MAG_W:0]    shift;
   logic [MAG_W+1:0]  diff;
   logic              ge;

   assign mag_a = dividend[VAL_W-1] ? VAL_W'(-dividend) : VAL_W'(dividend);
   assign mag_b = divisor[VAL_W-1]  ? VAL_W'(-divisor)  : VAL_W'(divisor);
   assign shift = {rem_ff, quo_ff[MAG_W-1]};
   assign diff  = {1'b0, shift} - {2'b00, dvs_ff};
   assign ge    = ~diff[MAG_W+1];

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      step_in  = step_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      dvs_in   = dvs_ff;
      neg_q_in = neg_q_ff;
      neg_r_in = neg_r_ff;
      if (start) begin
         busy_in  = 1'b1;
         step_in  = '0;
         quo_in   = mag_a[MAG_W-1:0];
         rem_in   = '0;
         dvs_in   = mag_b[MAG_W-1:0];
         neg_q_in = dividend[VAL_W-1] ^ divisor[VAL_W-1];
         neg_r_in = dividend[VAL_W-1];
      end else if (busy_ff) begin
         rem_in  = ge ? diff[MAG_W-1:0] : shift[MAG_W-1:0];
         quo_in  = {quo_ff[MAG_W-2:0], ge};
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_W'(MAG_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff   <= quo_in;
      rem_ff   <= rem_in;
      dvs_ff   <= dvs_in;
      neg_q_ff <= neg_q_in;
      neg_r_ff <= neg_r_in;
   end

   assign done      = done_ff;
   assign quotient  = neg_q_ff ? -$signed({1'b0, quo_ff}) : $signed({1'b0, quo_ff});
   assign remainder = neg_r_ff ? -$signed({1'b0, rem_ff}) : $signed({1'b0, rem_ff});

endmodule

`default_nettype wire

@@ rtl/csc_datapath.sv @@
// csc_datapath: stack memory, count and error flag, alu, divider and
// result register; uses csc_pkg and csc_divider
`default_nettype none

module csc_datapath (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire csc_pkg::csc_cmd_type             cmd,
   output csc_pkg::csc_status_type               status,
   input  wire logic signed [csc_pkg::VAL_W-1:0] req_operand,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output logic signed [csc_pkg::VAL_W-1:0]      rsp_result_value,
   output logic                                  rsp_error
);
   import csc_pkg::*;

   logic [VAL_W-1:0]        stack_mem [STACK_DEPTH];

   logic [CNT_W-1:0]        count_ff, count_in;
   logic                    error_ff, error_in;
   logic signed [VAL_W-1:0] operand_ff;
   logic signed [VAL_W-1:0] rd_data_ff;
   logic signed [VAL_W-1:0] rhs_ff;
   logic signed [RES_W-1:0] res_ff, res_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic signed [VAL_W-1:0] rsp_value_ff;
   logic                    rsp_error_ff;

   logic [CNT_W-1:0]        count_m1;
   logic [CNT_W-1:0]        count_m2;
   logic [ADDR_W-1:0]       rd_addr;
   logic [ADDR_W-1:0]       wr_addr;
   logic [VAL_W-1:0]        wr_data;
   logic signed [RES_W-1:0] lhs_ext;
   logic signed [RES_W-1:0] rhs_ext;
   logic signed [RES_W-1:0] mul_full;
   logic                    fin_bad;
   logic                    div_done;
   logic signed [VAL_W-1:0] div_q;
   logic signed [VAL_W-1:0] div_r;

   assign count_m1 = count_ff - CNT_W'(1);
   assign count_m2 = count_ff - CNT_W'(2);

   always_comb begin
      case (cmd.rd_addr_sel)
         A_TOP:    rd_addr = count_m1[ADDR_W-1:0];
         A_SECOND: rd_addr = count_m2[ADDR_W-1:0];
         A_PUSH:   rd_addr = count_ff[ADDR_W-1:0];
         default:  rd_addr = '0;
      endcase
      case (cmd.wr_addr_sel)
         A_TOP:    wr_addr = count_m1[ADDR_W-1:0];
         A_SECOND: wr_addr = count_m2[ADDR_W-1:0];
         A_PUSH:   wr_addr = count_ff[ADDR_W-1:0];
         default:  wr_addr = '0;
      endcase
      case (cmd.wr_data_sel)
         D_OPERAND: wr_data = operand_ff;
         D_READ:    wr_data = rd_data_ff;
         D_NEG:     wr_data = -rd_data_ff;
         D_RHS:     wr_data = rhs_ff;
         D_RESULT:  wr_data = res_ff[VAL_W-1:0];
         default:   wr_data = rd_data_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         stack_mem[wr_addr] <= wr_data;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= stack_mem[rd_addr];
      end
   end

   always_comb begin
      case (cmd.cnt_op)
         CNT_ZERO: count_in = '0;
         CNT_ONE:  count_in = CNT_W'(1);
         CNT_INC:  count_in = count_ff + CNT_W'(1);
         CNT_DEC:  count_in = count_m1;
         CNT_SUB2: count_in = count_m2;
         default:  count_in = count_ff;
      endcase
      if (cmd.err_set) begin
         error_in = 1'b1;
      end else if (cmd.err_clr) begin
         error_in = 1'b0;
      end else begin
         error_in = error_ff;
      end
   end

   // alu, lhs is the last word read from the stack
   assign lhs_ext  = RES_W'(rd_data_ff);
   assign rhs_ext  = RES_W'(rhs_ff);
   assign mul_full = lhs_ext * rhs_ext;

   always_comb begin
      res_in = res_ff;
      if (cmd.res_load_arith) begin
         case (cmd.op)
            OP_ADD:  res_in = lhs_ext + rhs_ext;
            OP_SUB:  res_in = lhs_ext - rhs_ext;
            OP_MUL:  res_in = mul_full;
            default: res_in = res_ff;
         endcase
      end else if (cmd.res_load_div) begin
         res_in = (cmd.op == OP_DIV) ? RES_W'(div_q) : RES_W'(div_r);
      end
   end

   csc_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (rd_data_ff),
      .divisor   (rhs_ff),
      .done      (div_done),
      .quotient  (div_q),
      .remainder (div_r)
   );

   assign fin_bad      = error_ff || (count_ff != CNT_W'(1));
   assign rsp_valid_in = cmd.rsp_load ? 1'b1 : (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         error_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         error_ff     <= error_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         operand_ff <= req_operand;
      end
      if (cmd.rhs_load) begin
         rhs_ff <= rd_data_ff;
      end
      res_ff <= res_in;
      if (cmd.rsp_load) begin
         rsp_value_ff <= fin_bad ? '0 : rd_data_ff;
         rsp_error_ff <= fin_bad;
      end
   end

   always_comb begin
      status.empty      = (count_ff == '0);
      status.lt2        = (count_ff < CNT_W'(2));
      status.full       = (count_ff >= CNT_W'(STACK_DEPTH));
      status.err        = error_ff;
      status.operand_ok = (operand_ff <= LIMIT_VAL) && (operand_ff >= -LIMIT_VAL);
      status.rhs_zero   = (rhs_ff == '0);
      status.res_ok     = (res_ff <= LIMIT_RES) && (res_ff >= -LIMIT_RES);
      status.div_done   = div_done;
      status.rsp_free   = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_value = rsp_value_ff;
   assign rsp_error        = rsp_error_ff;

endmodule

`default_nettype wire

@@ rtl/csc_ctrl.sv @@
// csc_ctrl: instruction sequencer state machine that drives the datapath
// through command signals; uses csc_pkg
`default_nettype none

module csc_ctrl (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire logic [csc_pkg::OP_W-1:0]        req_operation,
   input  wire csc_pkg::csc_status_type         status,
   output csc_pkg::csc_cmd_type                 cmd
);
   import csc_pkg::*;

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_DECODE = 4'd1;
   localparam logic [3:0] S_UNARY  = 4'd2;
   localparam logic [3:0] S_RD2    = 4'd3;
   localparam logic [3:0] S_EXEC   = 4'd4;
   localparam logic [3:0] S_SWP2   = 4'd5;
   localparam logic [3:0] S_DIV    = 4'd6;
   localparam logic [3:0] S_WB     = 4'd7;
   localparam logic [3:0] S_FIN    = 4'd8;

   logic [3:0]      state_ff, state_in;
   logic [OP_W-1:0] op_ff, op_in;

   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      req_ready = (state_ff == S_IDLE);
      cmd       = '0;
      cmd.op    = op_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               op_in       = req_operation;
               state_in    = S_DECODE;
            end
         end
         S_DECODE: begin
            state_in = S_IDLE;
            if (op_ff == OP_START) begin
               cmd.err_clr = 1'b1;
               if (status.operand_ok) begin
                  cmd.wr_en       = 1'b1;
                  cmd.wr_addr_sel = A_BOTTOM;
                  cmd.wr_data_sel = D_OPERAND;
                  cmd.cnt_op      = CNT_ONE;
               end else begin
                  cmd.cnt_op  = CNT_ZERO;
                  cmd.err_set = 1'b1;
               end
            end else if (op_ff == OP_FINISH) begin
               cmd.rd_en       = 1'b1;
               cmd.rd_addr_sel = A_BOTTOM;
               state_in        = S_FIN;
            end else if (status.err || op_ff > OP_FINISH) begin
               state_in = S_IDLE;
            end else begin
               case (op_ff)
                  OP_NUM: begin
                     if (!status.operand_ok || status.full) begin
                        cmd.err_set = 1'b1;
                     end else begin
                        cmd.wr_en       = 1'b1;
                        cmd.wr_addr_sel = A_PUSH;
                        cmd.wr_data_sel = D_OPERAND;
                        cmd.cnt_op      = CNT_INC;
                     end
                  end
                  OP_POP: begin
                     if (status.empty) begin
                        cmd.err_set = 1'b1;
                     end else begin
                        cmd.cnt_op = CNT_DEC;
                     end
                  end
                  OP_INV, OP_DUP: begin
                     if (status.empty) begin
                        cmd.err_set = 1'b1;
                     end else begin
                        cmd.rd_en       = 1'b1;
                        cmd.rd_addr_sel = A_TOP;
                        state_in        = S_UNARY;
                     end
                  end
                  default: begin
                     if (status.lt2) begin
                        cmd.err_set = 1'b1;
                     end else begin
                        cmd.rd_en       = 1'b1;
                        cmd.rd_addr_sel = A_TOP;
                        state_in        = S_RD2;
                     end
                  end
               endcase
            end
         end
         S_UNARY: begin
            state_in = S_IDLE;
            if (op_ff == OP_INV) begin
               cmd.wr_en       = 1'b1;
               cmd.wr_addr_sel = A_TOP;
               cmd.wr_data_sel = D_NEG;
            end else if (status.full) begin
               cmd.err_set = 1'b1;
            end else begin
               cmd.wr_en       = 1'b1;
               cmd.wr_addr_sel = A_PUSH;
               cmd.wr_data_sel = D_READ;
               cmd.cnt_op      = CNT_INC;
            end
         end
         S_RD2: begin
            cmd.rhs_load    = 1'b1;
            cmd.rd_en       = 1'b1;
            cmd.rd_addr_sel = A_SECOND;
            state_in        = S_EXEC;
         end
         S_EXEC: begin
            if (op_ff == OP_SWP) begin
               cmd.wr_en       = 1'b1;
               cmd.wr_addr_sel = A_TOP;
               cmd.wr_data_sel = D_READ;
               state_in        = S_SWP2;
            end else if (op_ff == OP_DIV || op_ff == OP_MOD) begin
               if (status.rhs_zero) begin
                  cmd.err_set = 1'b1;
                  state_in    = S_IDLE;
               end else begin
                  cmd.div_start = 1'b1;
                  state_in      = S_DIV;
               end
            end else begin
               cmd.res_load_arith = 1'b1;
               state_in           = S_WB;
            end
         end
         S_SWP2: begin
            cmd.wr_en       = 1'b1;
            cmd.wr_addr_sel = A_SECOND;
            cmd.wr_data_sel = D_RHS;
            state_in        = S_IDLE;
         end
         S_DIV: begin
            if (status.div_done) begin
               cmd.res_load_div = 1'b1;
               state_in         = S_WB;
            end
         end
         S_WB: begin
            state_in = S_IDLE;
            if (status.res_ok) begin
               cmd.wr_en       = 1'b1;
               cmd.wr_addr_sel = A_SECOND;
               cmd.wr_data_sel = D_RESULT;
               cmd.cnt_op      = CNT_DEC;
            end else begin
               cmd.cnt_op  = CNT_SUB2;
               cmd.err_set = 1'b1;
            end
         end
         S_FIN: begin
            if (status.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff <= op_in;
   end

endmodule

`default_nettype wire

@@ rtl/checked_stack_calculator_top.sv @@
// checked_stack_calculator_top: one instruction per item, result on finish
// div/mod use a 30-step iterative divider; a new instruction is accepted only
// once the previous one has finished
// reset: synchronous; clears stack count, error flag, sequencer and output valid
// uses csc_pkg, csc_ctrl and csc_datapath
`default_nettype none

module checked_stack_calculator_top (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire logic [csc_pkg::OP_W-1:0]         req_operation,
   input  wire logic signed [csc_pkg::VAL_W-1:0] req_operand,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output logic signed [csc_pkg::VAL_W-1:0]      rsp_result_value,
   output logic                                  rsp_error
);
   import csc_pkg::*;

   csc_cmd_type    cmd;
   csc_status_type status;

   csc_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_operation (req_operation),
      .status        (status),
      .cmd           (cmd)
   );

   csc_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_operand      (req_operand),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_result_value (rsp_result_value),
      .rsp_error        (rsp_error)
   );

endmodule

`default_nettype wire

@@ rtl/csc_checker.sv @@
// csc_checker: port-level assertions for checked_stack_calculator_top
// and the bind that attaches them; uses csc_pkg
`default_nettype none

module csc_checker (
   input wire logic                             clock,
   input wire logic                             reset,
   input wire logic                             req_valid,
   input wire logic                             req_ready,
   input wire logic [csc_pkg::OP_W-1:0]         req_operation,
   input wire logic signed [csc_pkg::VAL_W-1:0] req_operand,
   input wire logic                             rsp_valid,
   input wire logic                             rsp_ready,
   input wire logic signed [csc_pkg::VAL_W-1:0] rsp_result_value,
   input wire logic                             rsp_error
);
   import csc_pkg::*;

   logic unused_ok;
   assign unused_ok = ^{req_operation, req_operand};

   // stalled item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_result_value)
                                  && $stable(rsp_error))
      else $error("rsp item changed while stalled");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error |-> rsp_result_value == '0)
      else $error("error item carries nonzero value");

   a_val_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_error |-> rsp_result_value <= LIMIT_VAL
                                  && rsp_result_value >= -LIMIT_VAL)
      else $error("result value out of range");

   // req_ready drops after an instruction is accepted
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("item accepted in back-to-back cycles");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid after reset");

endmodule

bind checked_stack_calculator_top csc_checker u_csc_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .req_operation    (req_operation),
   .req_operand      (req_operand),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_result_value (rsp_result_value),
   .rsp_error        (rsp_error)
);

`default_nettype wire
